@@ design/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [0:0] csr_index_type;
   typedef logic [2:0] param_index_type;

   localparam int DEFAULT_BUFFER_DEPTH = 32;
   localparam int DEFAULT_MAX_PARAMS   = 4;
   localparam int MAX_RESULTS          = 32;

   localparam byte_type BYTE_CR     = 8'd13;
   localparam byte_type BYTE_LF     = 8'd10;
   localparam byte_type BYTE_SPACE  = 8'd32;
   localparam byte_type BYTE_BS     = 8'd8;
   localparam byte_type BYTE_PROMPT = 8'd62;
   localparam byte_type BYTE_ZERO   = 8'd0;

   localparam byte_type RESET_BACKSPACE_CODE = 8'd8;
   localparam byte_type RESET_KILL_CODE      = 8'd3;

   localparam csr_index_type REG_BACKSPACE = 1'd0;
   localparam csr_index_type REG_KILL      = 1'd1;

   typedef logic [1:0] echo_kind_type;
   localparam echo_kind_type ECHO_PROMPT   = 2'd0;
   localparam echo_kind_type ECHO_ERASE    = 2'd1;
   localparam echo_kind_type ECHO_CHAR     = 2'd2;
   localparam echo_kind_type ECHO_OVERFLOW = 2'd3;

endpackage

`default_nettype wire

@@ design/serial_line_editor.sv @@
// Channel   Direction  Handshake             Payload
// req_      in         req_valid/req_stall   req_rx_byte
// rsp_      out        rsp_valid/rsp_stall   out_byte, destination, is_separator,
//                                            param_index, overflow, last
// csr_      in         csr_write_en          csr_index, csr_write_data
//
// One item is worked on at a time. An echo item sends one to three echoed bytes; a
// line item of N bytes is read back through the single read port of the line memory,
// which delivers one byte a cycle while rsp_ is not stalled.
// Synchronous reset clears state, pointers and rsp_valid and restores the CSR codes;
// the memory is not cleared. A stall on rsp_ holds the current result and pauses the sequence in place.
`default_nettype none

module serial_line_editor
#(
   parameter int BUFFER_DEPTH = sle_pkg::DEFAULT_BUFFER_DEPTH,
   parameter int MAX_PARAMS   = sle_pkg::DEFAULT_MAX_PARAMS
)
(
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_stall,
   input  wire sle_pkg::byte_type       req_rx_byte,
   output logic                         rsp_valid,
   input  wire                          rsp_stall,
   output sle_pkg::byte_type            rsp_out_byte,
   output logic                         rsp_destination,
   output logic                         rsp_is_separator,
   output sle_pkg::param_index_type     rsp_param_index,
   output logic                         rsp_overflow,
   output logic                         rsp_last,
   input  wire                          csr_write_en,
   input  wire sle_pkg::csr_index_type  csr_index,
   input  wire sle_pkg::byte_type       csr_write_data
);

   import sle_pkg::*;

   localparam int PW       = $clog2(BUFFER_DEPTH);
   localparam int PIW      = $clog2(MAX_PARAMS + 1);
   localparam int LINE_CAP = ((BUFFER_DEPTH - 1) < MAX_RESULTS) ? (BUFFER_DEPTH - 1)
                                                                 : MAX_RESULTS;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_ECHO = 2'd1;
   localparam logic [1:0] ST_READ = 2'd2;
   localparam logic [1:0] ST_LINE = 2'd3;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      ptr_inc = (p == PW'(BUFFER_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PW-1:0] ptr_dec(input logic [PW-1:0] p);
      ptr_dec = (p == '0) ? PW'(BUFFER_DEPTH - 1) : p - 1'b1;
   endfunction

   byte_type              line_mem [BUFFER_DEPTH];
   byte_type              mem_q_ff;
   logic [PW-1:0]         rd_addr;
   logic                  mem_we;

   logic [1:0]            state_ff, state_in;
   logic [PW-1:0]         wp_ff, wp_in;
   logic [PW-1:0]         rp_ff, rp_in;
   logic [PW-1:0]         line_addr_ff, line_addr_in;
   logic [PW-1:0]         remain_ff, remain_in;
   logic [PIW-1:0]        pidx_ff, pidx_in;
   echo_kind_type         kind_ff, kind_in;
   logic [1:0]            step_ff, step_in;
   byte_type              char_ff, char_in;
   byte_type              bs_code_ff, kill_code_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   byte_type              out_byte_ff, out_byte_in;
   logic                  dest_ff, dest_in;
   logic                  sep_ff, sep_in;
   param_index_type       pidx_out_ff, pidx_out_in;
   logic                  ovf_ff, ovf_in;
   logic                  last_ff, last_in;

   logic                  accept;
   logic                  out_free;
   logic [PW:0]           cnt_wide;
   logic [PW-1:0]         cnt;
   logic                  is_eol;
   byte_type              echo_byte;
   logic                  echo_final;
   logic                  line_sep;
   logic [PIW-1:0]        line_pidx;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign cnt_wide = (wp_ff >= rp_ff) ? ({1'b0, wp_ff} - {1'b0, rp_ff})
                   : ({1'b0, wp_ff} + (PW+1)'(BUFFER_DEPTH) - {1'b0, rp_ff});
   assign cnt      = cnt_wide[PW-1:0];
   assign is_eol   = req_rx_byte inside {BYTE_CR, BYTE_LF};

   assign line_sep  = (mem_q_ff == BYTE_SPACE) && (pidx_ff < PIW'(MAX_PARAMS));
   assign line_pidx = line_sep ? pidx_ff + 1'b1 : pidx_ff;

   always_comb begin
      echo_byte  = BYTE_ZERO;
      echo_final = 1'b1;
      case (kind_ff)
         ECHO_PROMPT: begin
            echo_final = (step_ff == 2'd2);
            case (step_ff)
               2'd0:    echo_byte = BYTE_CR;
               2'd1:    echo_byte = BYTE_LF;
               default: echo_byte = BYTE_PROMPT;
            endcase
         end
         ECHO_ERASE: begin
            echo_final = (step_ff == 2'd2);
            echo_byte  = (step_ff == 2'd1) ? BYTE_SPACE : BYTE_BS;
         end
         ECHO_CHAR:     echo_byte = char_ff;
         ECHO_OVERFLOW: echo_byte = BYTE_ZERO;
         default:       echo_byte = BYTE_ZERO;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      rp_in        = rp_ff;
      line_addr_in = line_addr_ff;
      remain_in    = remain_ff;
      pidx_in      = pidx_ff;
      kind_in      = kind_ff;
      step_in      = step_ff;
      char_in      = char_ff;
      mem_we       = 1'b0;
      rd_addr      = line_addr_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      out_byte_in  = out_byte_ff;
      dest_in      = dest_ff;
      sep_in       = sep_ff;
      pidx_out_in  = pidx_out_ff;
      ovf_in       = ovf_ff;
      last_in      = last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               step_in = 2'd0;
               char_in = req_rx_byte;
               if (is_eol) begin
                  if (cnt == '0) begin
                     kind_in  = ECHO_PROMPT;
                     state_in = ST_ECHO;
                  end else begin
                     rp_in        = wp_ff;
                     line_addr_in = ptr_inc(rp_ff);
                     remain_in    = cnt;
                     pidx_in      = '0;
                     state_in     = ST_READ;
                  end
               end else if (req_rx_byte == kill_code_ff) begin
                  rp_in    = wp_ff;
                  kind_in  = ECHO_PROMPT;
                  state_in = ST_ECHO;
               end else if (req_rx_byte == bs_code_ff) begin
                  if (cnt != '0) begin
                     wp_in = ptr_dec(wp_ff);
                  end
                  kind_in  = ECHO_ERASE;
                  state_in = ST_ECHO;
               end else if (cnt >= PW'(LINE_CAP)) begin
                  kind_in  = ECHO_OVERFLOW;
                  state_in = ST_ECHO;
               end else begin
                  wp_in    = ptr_inc(wp_ff);
                  mem_we   = 1'b1;
                  kind_in  = ECHO_CHAR;
                  state_in = ST_ECHO;
               end
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = echo_byte;
               dest_in      = 1'b0;
               sep_in       = 1'b0;
               pidx_out_in  = '0;
               ovf_in       = (kind_ff == ECHO_OVERFLOW);
               last_in      = echo_final;
               step_in      = step_ff + 1'b1;
               if (echo_final) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LINE;
         end
         ST_LINE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               out_byte_in  = mem_q_ff;
               dest_in      = 1'b1;
               sep_in       = line_sep;
               pidx_out_in  = 3'(line_pidx);
               ovf_in       = 1'b0;
               last_in      = (remain_ff == PW'(1));
               pidx_in      = line_pidx;
               remain_in    = remain_ff - 1'b1;
               line_addr_in = ptr_inc(line_addr_ff);
               rd_addr      = ptr_inc(line_addr_ff);
               if (remain_ff == PW'(1)) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_mem[wp_in] <= req_rx_byte;
      end
      mem_q_ff <= line_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         rp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         bs_code_ff   <= RESET_BACKSPACE_CODE;
         kill_code_ff <= RESET_KILL_CODE;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_en) begin
            case (csr_index)
               REG_BACKSPACE: bs_code_ff   <= csr_write_data;
               REG_KILL:      kill_code_ff <= csr_write_data;
               default:       ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      line_addr_ff <= line_addr_in;
      remain_ff    <= remain_in;
      pidx_ff      <= pidx_in;
      kind_ff      <= kind_in;
      step_ff      <= step_in;
      char_ff      <= char_in;
      out_byte_ff  <= out_byte_in;
      dest_ff      <= dest_in;
      sep_ff       <= sep_in;
      pidx_out_ff  <= pidx_out_in;
      ovf_ff       <= ovf_in;
      last_ff      <= last_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_destination  = dest_ff;
   assign rsp_is_separator = sep_ff;
   assign rsp_param_index  = pidx_out_ff;
   assign rsp_overflow     = ovf_ff;
   assign rsp_last         = last_ff;

endmodule

`default_nettype wire
